### hw/rtl/abis_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the array binary search tree block.
// No dependencies.
package abis_pkg;

    localparam int KEY_W  = 32;
    localparam int SLOT_W = 8;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_MIN    = 2'd2;
    localparam logic [1:0] REQ_MAX    = 2'd3;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_MISS = 3'd1;
    localparam logic [2:0] ST_DUP  = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_ZERO = 3'd4;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [2:0]              status;
        logic [SLOT_W-1:0]       slot_index;
        logic signed [KEY_W-1:0] value;
    } t_rsp;

    typedef struct packed {
        logic clear_en;
        logic start;
        logic walk;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic zero_key;
        logic walk_done;
        logic out_free;
    } t_sts;

endpackage

### hw/rtl/abis_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module abis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 255
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/abis_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: clear pass, accept, tree walk, result handoff.
// Depends on abis_pkg.
module abis_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  abis_pkg::t_sts i_sts,
    output abis_pkg::t_cmd o_cmd
);
    import abis_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_req_ready    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_sts.zero_key ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/abis_datapath.sv
`timescale 1ns / 1ps
// Datapath: slot store, walk index and compare, result and output registers.
// Depends on abis_pkg and abis_ram.
module abis_datapath #(
    parameter int SLOTS = 255
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  abis_pkg::t_req i_req,
    input  abis_pkg::t_cmd i_cmd,
    output abis_pkg::t_sts o_sts,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output abis_pkg::t_rsp o_rsp
);
    import abis_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int NXT_W = IDX_W + 2;
    localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    function automatic logic [SLOT_W-1:0] slot8(input logic [IDX_W-1:0] idx);
        logic [EXT_W-1:0] ext;
        ext   = EXT_W'(idx);
        slot8 = ext[SLOT_W-1:0];
    endfunction

    logic [1:0]              r_type;
    logic signed [KEY_W-1:0] r_key;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_prev_idx;
    logic [KEY_W-1:0]        r_prev_val;
    logic [IDX_W-1:0]        r_clr;
    t_rsp                    r_res;
    t_rsp                    r_out;
    logic                    r_out_valid;

    logic [KEY_W-1:0]        ram_q;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [KEY_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;

    logic                    is_ext;
    logic                    is_empty;
    logic                    is_eq;
    logic                    go_right;
    logic [NXT_W-1:0]        nxt;
    logic                    past_end;
    logic                    done;
    logic                    ins_wr;
    t_rsp                    res;

    abis_ram #(
        .WIDTH(KEY_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    always_comb begin
        is_ext   = (r_type == REQ_MIN) || (r_type == REQ_MAX);
        is_empty = (ram_q == '0);
        is_eq    = (r_key == $signed(ram_q));
        go_right = is_ext ? (r_type == REQ_MAX) : (r_key > $signed(ram_q));
        nxt      = (NXT_W'(r_idx) << 1) + (go_right ? NXT_W'(2) : NXT_W'(1));
        past_end = (nxt >= NXT_W'(SLOTS));
        done     = 1'b1;
        ins_wr   = 1'b0;
        res      = '{status: ST_MISS, slot_index: '0, value: '0};
        if (is_ext) begin
            priority if (is_empty) begin
                if (r_idx != '0) begin
                    res = '{status: ST_OK, slot_index: slot8(r_prev_idx),
                            value: $signed(r_prev_val)};
                end
            end else if (past_end) begin
                res = '{status: ST_OK, slot_index: slot8(r_idx), value: $signed(ram_q)};
            end else begin
                done = 1'b0;
            end
        end else begin
            priority if (is_empty) begin
                if (r_type == REQ_INSERT) begin
                    ins_wr = 1'b1;
                    res = '{status: ST_OK, slot_index: slot8(r_idx), value: r_key};
                end
            end else if (is_eq) begin
                res = '{status: (r_type == REQ_INSERT) ? ST_DUP : ST_OK,
                        slot_index: slot8(r_idx), value: $signed(ram_q)};
            end else if (past_end) begin
                if (r_type == REQ_INSERT) begin
                    res.status = ST_FULL;
                end
            end else begin
                done = 1'b0;
            end
        end
    end

    always_comb begin
        ram_we    = i_cmd.clear_en || (i_cmd.walk && ins_wr);
        ram_waddr = i_cmd.clear_en ? r_clr : r_idx;
        ram_wdata = i_cmd.clear_en ? '0 : KEY_W'(r_key);
        ram_raddr = (i_cmd.walk && !done) ? nxt[IDX_W-1:0] : '0;
    end

    always_comb begin
        o_sts.clear_last = (r_clr == IDX_W'(SLOTS - 1));
        o_sts.zero_key   = ((i_req.req_type == REQ_INSERT) || (i_req.req_type == REQ_SEARCH))
                           && (i_req.key == '0);
        o_sts.walk_done  = done;
        o_sts.out_free   = !r_out_valid || i_rsp_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_en) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_type <= i_req.req_type;
            r_key  <= i_req.key;
            r_idx  <= '0;
            r_res  <= '{status: ST_ZERO, slot_index: '0, value: '0};
        end else if (i_cmd.walk) begin
            if (done) begin
                r_res <= res;
            end else begin
                r_prev_idx <= r_idx;
                r_prev_val <= ram_q;
                r_idx      <= nxt[IDX_W-1:0];
            end
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk |-> (r_idx < IDX_W'(SLOTS)))
        else $error("walk index beyond store");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_rsp_ready))
        else $error("pending result overwritten");

    a_walk_nonzero_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && i_cmd.walk) |-> (ram_wdata != '0))
        else $error("zero key written into tree");

    a_wr_only_clear_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (i_cmd.clear_en || (i_cmd.walk && is_empty && (r_type == REQ_INSERT))))
        else $error("unexpected store write");

endmodule

### hw/rtl/array_bst_insert_search.sv
`timescale 1ns / 1ps
// Top level of the array-held binary search tree (insert, search, min, max).
// Depends on abis_pkg, abis_ctrl, abis_datapath.
//
// Request channel: i_req_valid / o_req_ready carry req_type and key; one
// transfer per request. Response channel: o_rsp_valid / i_rsp_ready carry
// status, slot_index and value; exactly one response per request, in order.
// One request is in work at a time. The walk visits 1 to ceil(log2(SLOTS+1))
// tree levels, up to 8 at 255 slots, and reads one slot of the store per
// cycle through the RAM read port. Its result is registered, then moved to
// the output register once that register is free; only then can the next
// request transfer. Zero-key rejects skip the walk and go straight to that
// handoff. The output register holds a finished response while the
// receiver stalls; the next request is taken meanwhile and waits for the
// register to free.
// After reset the store is swept to zero, one slot per cycle, through all
// SLOTS slots; o_req_ready stays low during that sweep.
module array_bst_insert_search #(
    parameter int SLOTS = 255
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  abis_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output abis_pkg::t_rsp o_rsp
);
    import abis_pkg::*;

    t_cmd cmd;
    t_sts sts;

    abis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    abis_datapath #(
        .SLOTS(SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

endmodule

### dv/array_bst_insert_search_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for array_bst_insert_search: directed and random insert, search,
// min and max requests checked against a shadow copy of the tree store.
// Depends on abis_pkg and the array_bst_insert_search RTL.
module array_bst_insert_search_test;
    import abis_pkg::*;

    localparam int TREE_SLOTS = 255;
    localparam int CLK_HALF   = 5;

    logic i_clk   = 1'b0;
    logic rst_n   = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req_bus   = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp_bus;

    logic signed [KEY_W-1:0] shadow_tree [TREE_SLOTS];
    logic signed [KEY_W-1:0] seen_keys [$];
    t_req pending_q [$];
    t_rsp want_q [$];
    t_req nxt_req;

    int unsigned snd_idle_pct  = 0;
    int unsigned rcv_stall_pct = 0;
    int          queued_cnt    = 0;
    int          sent_cnt      = 0;
    int          got_cnt       = 0;
    int          fails         = 0;
    int          status_seen [5];
    logic        hold_arm      = 1'b0;
    int          hold_left     = 0;
    int          max_hold_seen = 0;

    array_bst_insert_search #(.SLOTS(TREE_SLOTS)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req_bus),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp_bus)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Walks the shadow tree exactly as the block should, updating it on insert.
    function automatic t_rsp tree_lookup(input t_req r);
        t_rsp                    res;
        int unsigned             idx;
        int unsigned             nxt;
        logic signed [KEY_W-1:0] k;
        logic signed [KEY_W-1:0] cur;
        bit                      done;
        res  = '0;
        k    = r.key;
        idx  = 0;
        done = 1'b0;
        if (r.req_type == REQ_INSERT || r.req_type == REQ_SEARCH) begin
            if (k == 0) begin
                res.status = ST_ZERO;
            end else begin
                res.status = (r.req_type == REQ_INSERT) ? ST_FULL : ST_MISS;
                while (!done && idx < TREE_SLOTS) begin
                    cur = shadow_tree[idx];
                    if (cur == 0) begin
                        done = 1'b1;
                        if (r.req_type == REQ_INSERT) begin
                            shadow_tree[idx] = k;
                            res.status       = ST_OK;
                            res.slot_index   = idx[SLOT_W-1:0];
                            res.value        = k;
                        end
                    end else if (cur == k) begin
                        done           = 1'b1;
                        res.status     = (r.req_type == REQ_INSERT) ? ST_DUP : ST_OK;
                        res.slot_index = idx[SLOT_W-1:0];
                        res.value      = cur;
                    end else begin
                        idx = (k > cur) ? 2 * idx + 2 : 2 * idx + 1;
                    end
                end
            end
        end else if (shadow_tree[0] == 0) begin
            res.status = ST_MISS;
        end else begin
            while (!done) begin
                nxt = (r.req_type == REQ_MAX) ? 2 * idx + 2 : 2 * idx + 1;
                if (nxt >= TREE_SLOTS || shadow_tree[nxt] == 0)
                    done = 1'b1;
                else
                    idx = nxt;
            end
            res.status     = ST_OK;
            res.slot_index = idx[SLOT_W-1:0];
            res.value      = shadow_tree[idx];
        end
        return res;
    endfunction

    task automatic queue_req(input logic [1:0] kind, input logic signed [KEY_W-1:0] k);
        t_req r;
        r.req_type = kind;
        r.key      = k;
        pending_q.push_back(r);
        queued_cnt++;
    endtask

    task automatic queue_random(input int n);
        int unsigned             roll;
        logic [1:0]              kind;
        logic signed [KEY_W-1:0] k;
        repeat (n) begin
            roll = $urandom_range(99);
            kind = (roll < 35) ? REQ_INSERT : (roll < 75) ? REQ_SEARCH :
                   (roll < 87) ? REQ_MIN : REQ_MAX;
            roll = $urandom_range(99);
            if (roll < 40 || (roll < 70 && seen_keys.size() == 0))
                k = $urandom;
            else if (roll < 70)
                k = seen_keys[$urandom_range(seen_keys.size() - 1)];
            else if (roll < 90)
                k = $urandom_range(1) ? $signed($urandom_range(64, 1)) :
                    -$signed($urandom_range(64, 1));
            else if (roll < 95)
                k = '0;
            else
                case ($urandom_range(3))
                    0: k = 32'sh7FFF_FFFF;
                    1: k = 32'sh8000_0000;
                    2: k = 32'sd1;
                    default: k = -32'sd1;
                endcase
            if (kind == REQ_INSERT && k != 0) begin
                seen_keys.push_back(k);
                if (seen_keys.size() > 64)
                    void'(seen_keys.pop_front());
            end
            queue_req(kind, k);
        end
    endtask

    task automatic wait_all_sent;
        do @(posedge i_clk); while (sent_cnt != queued_cnt);
    endtask

    // Sender: holds each request until its transfer, then predicts it.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && req_ready) begin
                want_q.push_back(tree_lookup(req_bus));
                sent_cnt++;
            end
            if (!req_valid || req_ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    nxt_req = pending_q.pop_front();
                    req_bus   <= nxt_req;
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, armed for one cycle by the main sequence.
    always @(posedge i_clk) begin
        if (hold_arm)
            hold_left <= 200;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: checks each response transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp want;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                got_cnt++;
                if (rsp_bus.status < 5)
                    status_seen[rsp_bus.status]++;
                if (want_q.size() == 0) begin
                    $display("%0t: unexpected response status %0d slot %0d value %0d",
                             $time, rsp_bus.status, rsp_bus.slot_index, rsp_bus.value);
                    fails++;
                end else begin
                    want = want_q.pop_front();
                    if (rsp_bus.status !== want.status) begin
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, want.status, rsp_bus.status);
                        fails++;
                    end
                    if (rsp_bus.slot_index !== want.slot_index) begin
                        $display("%0t: slot_index mismatch expected %0d actual %0d",
                                 $time, want.slot_index, rsp_bus.slot_index);
                        fails++;
                    end
                    if (rsp_bus.value !== want.value) begin
                        $display("%0t: value mismatch expected %0d actual %0d",
                                 $time, want.value, rsp_bus.value);
                        fails++;
                    end
                end
            end
            if (hold_left > max_hold_seen)
                max_hold_seen <= hold_left;
            rsp_ready <= (hold_arm || hold_left > 1) ? 1'b0 :
                         ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    initial begin
        int k;
        foreach (shadow_tree[i])
            shadow_tree[i] = '0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        // empty tree, zero keys, duplicate, rightmost chain until the store runs out
        queue_req(REQ_MIN, 32'sd7);
        queue_req(REQ_MAX, -32'sd7);
        queue_req(REQ_SEARCH, 32'sd5);
        queue_req(REQ_INSERT, 32'sd0);
        queue_req(REQ_SEARCH, 32'sd0);
        queue_req(REQ_INSERT, 32'sd16);
        queue_req(REQ_INSERT, 32'sd16);
        for (k = 1; k <= 7; k++)
            queue_req(REQ_INSERT, 32'sh1000_0000 * k);
        queue_req(REQ_INSERT, 32'sh7FFF_FFFF);
        queue_req(REQ_INSERT, 32'sh8000_0000);
        queue_req(REQ_INSERT, -32'sd1);
        queue_req(REQ_MIN, 32'sd0);
        queue_req(REQ_MAX, 32'sd0);
        queue_req(REQ_SEARCH, 32'sh7000_0000);
        queue_req(REQ_SEARCH, 32'sh7FFF_FFFF);
        queue_req(REQ_SEARCH, 32'sd50);
        queue_req(REQ_SEARCH, 32'sh8000_0000);
        queue_req(REQ_SEARCH, -32'sd1);
        wait_all_sent();

        // no idling, with a long receiver hold-off at the start
        queue_random(350);
        hold_arm <= 1'b1;
        @(posedge i_clk);
        hold_arm <= 1'b0;
        wait_all_sent();

        snd_idle_pct = 82;
        queue_random(250);
        wait_all_sent();

        snd_idle_pct  = 0;
        rcv_stall_pct = 82;
        queue_random(250);
        wait_all_sent();

        snd_idle_pct  = 18;
        rcv_stall_pct = 18;
        queue_random(400);
        wait_all_sent();

        while (want_q.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Ran %0d requests, %0d responses, receiver hold-off up to %0d cycles.",
                 sent_cnt, got_cnt, max_hold_seen);
        $display("Statuses seen: ok %0d, miss %0d, duplicate %0d, full %0d, zero key %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
